// ===== rtl/core/cds420_pkg.sv =====
// ----------------------------------------------------------------------------
// cds420_pkg
// Shared types and constants of the 4:2:0 chroma downsampler.
// ----------------------------------------------------------------------------
`default_nettype none

package cds420_pkg;

    localparam int DEFAULT_MAX_WIDTH_PAIRS  = 1024;
    localparam int DEFAULT_MAX_HEIGHT_PAIRS = 4096;

    localparam int PIX_W      = 8;
    localparam int PAIR_SUM_W = PIX_W + 1;
    localparam int LINE_W     = 2 * PAIR_SUM_W;
    localparam int TDATA_W    = 3 * PIX_W;

    localparam int WIDTH_REG_W  = 11;
    localparam int HEIGHT_REG_W = 13;
    localparam int SIZE_CMP_W   = 14;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] REG_WIDTH_PAIRS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_PAIRS = 2'd1;

    localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd320;
    localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd240;

    // Position status handed from the position control to the datapath.
    typedef struct packed {
        logic col_odd;
        logic row_odd;
        logic col_end;
        logic row_end;
    } cds_pos_t;

endpackage

`default_nettype wire

// ===== rtl/core/cds420_line_store.sv =====
// ----------------------------------------------------------------------------
// cds420_line_store
// Single-port-write, registered-read line memory for the even-row pair sums.
// ----------------------------------------------------------------------------
`default_nettype none

module cds420_line_store #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10,
    parameter int DATA_W = 18
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/cds420_ctrl.sv =====
// ----------------------------------------------------------------------------
// cds420_ctrl
// Size registers and raster position tracking (column pair, row pair, phases).
// ----------------------------------------------------------------------------
`default_nettype none

module cds420_ctrl #(
    parameter int MAX_WIDTH_PAIRS  = cds420_pkg::DEFAULT_MAX_WIDTH_PAIRS,
    parameter int MAX_HEIGHT_PAIRS = cds420_pkg::DEFAULT_MAX_HEIGHT_PAIRS,
    parameter int COL_W            = 10
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_valid,
    input  wire logic [cds420_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [cds420_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic                                 advance,
    output cds420_pkg::cds_pos_t                      pos,
    output logic      [COL_W-1:0]                     col_addr
);

    import cds420_pkg::*;

    localparam int ROW_W = (MAX_HEIGHT_PAIRS > 1) ? $clog2(MAX_HEIGHT_PAIRS) : 1;
    localparam logic [SIZE_CMP_W-1:0] MAX_W_CMP = SIZE_CMP_W'(MAX_WIDTH_PAIRS);
    localparam logic [SIZE_CMP_W-1:0] MAX_H_CMP = SIZE_CMP_W'(MAX_HEIGHT_PAIRS);

    logic [WIDTH_REG_W-1:0]  width_reg;
    logic [HEIGHT_REG_W-1:0] height_reg;
    logic [COL_W-1:0]        col_reg,     col_next;
    logic [ROW_W-1:0]        row_reg,     row_next;
    logic                    col_odd_reg, col_odd_next;
    logic                    row_odd_reg, row_odd_next;
    logic [SIZE_CMP_W-1:0]   w_eff;
    logic [SIZE_CMP_W-1:0]   h_eff;
    logic                    col_end;
    logic                    row_end;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_WIDTH_PAIRS:  width_reg  <= cfg_data[WIDTH_REG_W-1:0];
                REG_HEIGHT_PAIRS: height_reg <= cfg_data[HEIGHT_REG_W-1:0];
                default:          ;
            endcase
        end
    end

    // A size of zero counts as one, a size above the maximum as the maximum.
    always_comb
    begin
        w_eff = SIZE_CMP_W'(width_reg);
        if (w_eff == '0)
        begin
            w_eff = SIZE_CMP_W'(1);
        end
        else if (w_eff > MAX_W_CMP)
        begin
            w_eff = MAX_W_CMP;
        end

        h_eff = SIZE_CMP_W'(height_reg);
        if (h_eff == '0)
        begin
            h_eff = SIZE_CMP_W'(1);
        end
        else if (h_eff > MAX_H_CMP)
        begin
            h_eff = MAX_H_CMP;
        end
    end

    assign col_end = (SIZE_CMP_W'(col_reg) + SIZE_CMP_W'(1)) >= w_eff;
    assign row_end = (SIZE_CMP_W'(row_reg) + SIZE_CMP_W'(1)) >= h_eff;

    always_comb
    begin
        col_next     = col_reg;
        row_next     = row_reg;
        col_odd_next = col_odd_reg;
        row_odd_next = row_odd_reg;
        if (advance)
        begin
            col_odd_next = !col_odd_reg;
            if (col_odd_reg)
            begin
                if (col_end)
                begin
                    col_next     = '0;
                    row_odd_next = !row_odd_reg;
                    if (row_odd_reg)
                    begin
                        row_next = row_end ? '0 : row_reg + ROW_W'(1);
                    end
                end
                else
                begin
                    col_next = col_reg + COL_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg     <= '0;
            row_reg     <= '0;
            col_odd_reg <= 1'b0;
            row_odd_reg <= 1'b0;
        end
        else
        begin
            col_reg     <= col_next;
            row_reg     <= row_next;
            col_odd_reg <= col_odd_next;
            row_odd_reg <= row_odd_next;
        end
    end

    assign pos.col_odd = col_odd_reg;
    assign pos.row_odd = row_odd_reg;
    assign pos.col_end = col_end;
    assign pos.row_end = row_end;
    assign col_addr    = col_reg;

endmodule

`default_nettype wire

// ===== rtl/core/chroma_downsample_420_unit.sv =====
// An accepted input transaction is registered into the output register as its output transaction.
// Throughput: one pixel per cycle while the output is not stalled; the line store reads a pair's sum at the even
// pixel of an odd row and writes it at the odd pixel of an even row, one port each.
// The output register takes a new pixel in the cycle its old one is taken.
// Reset: sizes return to 320 x 240 pairs and the position to the top left; the
// line store is not cleared; it is written before it is read if sizes change only on an even row.
// ----------------------------------------------------------------------------
// chroma_downsample_420_unit
// 4:2:0 chroma subsampling by 2x2 block average over a raster pixel stream.
// ----------------------------------------------------------------------------
`default_nettype none

module chroma_downsample_420_unit #(
    parameter int MAX_WIDTH_PAIRS  = cds420_pkg::DEFAULT_MAX_WIDTH_PAIRS,
    parameter int MAX_HEIGHT_PAIRS = cds420_pkg::DEFAULT_MAX_HEIGHT_PAIRS
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // luma_in [7:0], cb_in [15:8], cr_in [23:16]
    input  wire logic [cds420_pkg::TDATA_W-1:0]     s_axis_tdata,
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // luma_out [7:0], cb_average [15:8], cr_average [23:16]
    output logic      [cds420_pkg::TDATA_W-1:0]     m_axis_tdata,
    // chroma_valid [0]
    output logic                                    m_axis_tuser,
    output logic                                    m_axis_tlast,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [cds420_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [cds420_pkg::CFG_DATA_W-1:0]  cfg_data
);

    import cds420_pkg::*;

    localparam int COL_W = (MAX_WIDTH_PAIRS > 1) ? $clog2(MAX_WIDTH_PAIRS) : 1;

    cds_pos_t                pos;
    logic [COL_W-1:0]        col_addr;
    logic                    accept;
    logic [PIX_W-1:0]        luma_in;
    logic [PIX_W-1:0]        cb_in;
    logic [PIX_W-1:0]        cr_in;
    logic [2*PIX_W-1:0]      held_reg;
    logic [PAIR_SUM_W-1:0]   cb_pair;
    logic [PAIR_SUM_W-1:0]   cr_pair;
    logic [LINE_W-1:0]       above;
    logic [PAIR_SUM_W:0]     cb_sum;
    logic [PAIR_SUM_W:0]     cr_sum;
    logic                    block_done;
    logic                    wr_en;
    logic                    rd_en;
    logic                    out_valid_reg;
    logic [TDATA_W-1:0]      out_data_next;
    logic [TDATA_W-1:0]      out_data_reg;
    logic                    out_user_reg;
    logic                    out_last_reg;

    assign luma_in = s_axis_tdata[PIX_W-1:0];
    assign cb_in   = s_axis_tdata[2*PIX_W-1:PIX_W];
    assign cr_in   = s_axis_tdata[3*PIX_W-1:2*PIX_W];

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;

    cds420_ctrl #(
        .MAX_WIDTH_PAIRS  (MAX_WIDTH_PAIRS),
        .MAX_HEIGHT_PAIRS (MAX_HEIGHT_PAIRS),
        .COL_W            (COL_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .advance   (accept),
        .pos       (pos),
        .col_addr  (col_addr)
    );

    // The sum above is fetched at the even pixel, so it is ready at the odd one.
    assign wr_en = accept && pos.col_odd && !pos.row_odd;
    assign rd_en = accept && !pos.col_odd && pos.row_odd;

    assign cb_pair = PAIR_SUM_W'(held_reg[2*PIX_W-1:PIX_W]) + PAIR_SUM_W'(cb_in);
    assign cr_pair = PAIR_SUM_W'(held_reg[PIX_W-1:0]) + PAIR_SUM_W'(cr_in);

    cds420_line_store #(
        .DEPTH  (MAX_WIDTH_PAIRS),
        .ADDR_W (COL_W),
        .DATA_W (LINE_W)
    ) u_line_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (col_addr),
        .wr_data ({cb_pair, cr_pair}),
        .rd_en   (rd_en),
        .rd_addr (col_addr),
        .rd_data (above)
    );

    assign cb_sum = (PAIR_SUM_W+1)'(above[LINE_W-1:PAIR_SUM_W]) + (PAIR_SUM_W+1)'(cb_pair);
    assign cr_sum = (PAIR_SUM_W+1)'(above[PAIR_SUM_W-1:0]) + (PAIR_SUM_W+1)'(cr_pair);
    assign block_done = pos.col_odd && pos.row_odd;

    always_comb
    begin
        out_data_next = {{(2*PIX_W){1'b0}}, luma_in};
        if (block_done)
        begin
            out_data_next = {cr_sum[PAIR_SUM_W:2], cb_sum[PAIR_SUM_W:2], luma_in};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= '0;
        end
        else if (accept && !pos.col_odd)
        begin
            held_reg <= {cb_in, cr_in};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            out_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= out_data_next;
            out_user_reg <= block_done;
            out_last_reg <= block_done && pos.col_end && pos.row_end;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

`default_nettype wire

// ===== rtl/core/cds420_checker.sv =====
// ----------------------------------------------------------------------------
// cds420_checker
// Port-level checks of the chroma downsampler's output stream.
// ----------------------------------------------------------------------------
`default_nettype none

module cds420_checker (
    input wire logic                            clk,
    input wire logic                            rst_n,
    input wire logic                            s_axis_tvalid,
    input wire logic                            s_axis_tready,
    input wire logic                            m_axis_tvalid,
    input wire logic                            m_axis_tready,
    input wire logic [cds420_pkg::TDATA_W-1:0]  m_axis_tdata,
    input wire logic                            m_axis_tuser,
    input wire logic                            m_axis_tlast
);

    import cds420_pkg::*;

    // The frame ends only on a pixel that completes a block.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tuser)
        else $error("frame end without a completed chroma block");

    // Chroma bytes are zero unless a block is completed.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[TDATA_W-1:PIX_W] == '0)
        else $error("chroma average present without a completed block");

    // Every accepted pixel produces an output transaction in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
        else $error("accepted pixel did not reach the output");

    // A stalled output holds its transaction.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled output transaction changed");

endmodule

bind chroma_downsample_420_unit cds420_checker u_cds420_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

// ===== test/chroma_downsample_420_unit_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// chroma_downsample_420_unit_test
// Streams YCbCr pixels through the 4:2:0 downsampler under random source gaps
// and sink stalls, predicts every output pixel and compares it field by field.
// ----------------------------------------------------------------------------

module chroma_downsample_420_unit_test;

    import cds420_pkg::*;

    localparam int MAX_W = DEFAULT_MAX_WIDTH_PAIRS;
    localparam int MAX_H = DEFAULT_MAX_HEIGHT_PAIRS;
    localparam int COL_AW = (MAX_W > 1) ? $clog2(MAX_W) : 1;

    // Register indexes that the block has no register behind.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_3 = 2'd3;

    localparam int CYCLE_LIMIT   = 500000;
    localparam int RANDOM_PIXELS = 650;
    localparam int DRAIN_CYCLES  = 4;

    // Opening pixels as {cr, cb, luma}. The first eight run at the reset size,
    // the rest after the size drops to one pair by one pair.
    localparam logic [TDATA_W-1:0] OPENING_PIXELS [24] = '{
        24'h000000, 24'hFFFFFF, 24'hFF00FF, 24'h00FF00,
        24'h030201, 24'h80FDFE, 24'h017F80, 24'h55AA55,
        24'h102030, 24'h405060, 24'h708090, 24'hA0B0C0,
        24'hFFFFFF, 24'hFFFF00, 24'hFFFF00, 24'hFFFFFF,
        24'h0000FF, 24'h000000, 24'h000000, 24'h0000FF,
        24'h030101, 24'h030101, 24'h030101, 24'h020000
    };

    typedef struct packed {
        logic [7:0] luma;
        logic [7:0] cb_avg;
        logic [7:0] cr_avg;
        logic       chroma_valid;
        logic       frame_last;
    } pixel_result_t;

    typedef enum int {RX_ALWAYS, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_t;

    class downsample_scoreboard;
        bit [WIDTH_REG_W-1:0]  width_reg;
        bit [HEIGHT_REG_W-1:0] height_reg;
        bit [LINE_W-1:0]       line_sums [MAX_W];
        bit [15:0]             left_chroma;
        int unsigned           col_pos;
        int unsigned           row_pos;
        bit                    col_odd;
        bit                    row_odd;
        pixel_result_t         expected_pixels [$];
        int                    errors;

        function new();
            width_reg   = WIDTH_RESET;
            height_reg  = HEIGHT_RESET;
            left_chroma = '0;
            col_pos     = 0;
            row_pos     = 0;
            col_odd     = 1'b0;
            row_odd     = 1'b0;
            errors      = 0;
        endfunction

        function int unsigned fit_size(input int unsigned v, input int unsigned top);
            if (v == 0)
                return 1;
            return (v > top) ? top : v;
        endfunction

        function void set_register(input logic [CFG_IDX_W-1:0] idx,
                                   input logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_WIDTH_PAIRS:  width_reg = data[WIDTH_REG_W-1:0];
                REG_HEIGHT_PAIRS: height_reg = data[HEIGHT_REG_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_pixel(input logic [7:0] y, input logic [7:0] cb,
                                 input logic [7:0] cr);
            int unsigned   w;
            int unsigned   h;
            bit            col_end;
            bit            row_end;
            bit [8:0]      cb_pair;
            bit [8:0]      cr_pair;
            bit [9:0]      cb_sum;
            bit [9:0]      cr_sum;
            bit [LINE_W-1:0] above;
            pixel_result_t r;
            w = fit_size(32'(width_reg), MAX_W);
            h = fit_size(32'(height_reg), MAX_H);
            col_end = (col_pos + 1) >= w;
            row_end = (row_pos + 1) >= h;
            r = '0;
            r.luma = y;
            if (!col_odd) begin
                left_chroma = {cb, cr};
            end
            else begin
                cb_pair = left_chroma[15:8] + cb;
                cr_pair = left_chroma[7:0] + cr;
                if (!row_odd) begin
                    if (col_pos < MAX_W)
                        line_sums[col_pos[COL_AW-1:0]] = {cb_pair, cr_pair};
                end
                else begin
                    above = (col_pos < MAX_W) ? line_sums[col_pos[COL_AW-1:0]] : '0;
                    cb_sum = above[LINE_W-1:PAIR_SUM_W] + cb_pair;
                    cr_sum = above[PAIR_SUM_W-1:0] + cr_pair;
                    r.cb_avg = cb_sum[9:2];
                    r.cr_avg = cr_sum[9:2];
                    r.chroma_valid = 1'b1;
                    r.frame_last = col_end && row_end;
                end
            end
            // The column and row walk advances only on the odd pixel of a pair.
            if (!col_odd) begin
                col_odd = 1'b1;
            end
            else begin
                col_odd = 1'b0;
                if (col_end) begin
                    col_pos = 0;
                    if (!row_odd) begin
                        row_odd = 1'b1;
                    end
                    else begin
                        row_odd = 1'b0;
                        row_pos = row_end ? 0 : ((row_pos + 1) & 32'h1FFF);
                    end
                end
                else begin
                    col_pos = (col_pos + 1) & 32'h7FF;
                end
            end
            expected_pixels.push_back(r);
        endfunction

        function void compare_field(input string name, input logic [7:0] want,
                                    input logic [7:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
            end
        endfunction

        function void check_result(input pixel_result_t got);
            pixel_result_t want;
            if (expected_pixels.size() == 0) begin
                errors++;
                $display("%0t: expected no output transaction, actual luma %0d",
                         $time, got.luma);
                return;
            end
            want = expected_pixels.pop_front();
            compare_field("luma_out", want.luma, got.luma);
            compare_field("cb_average", want.cb_avg, got.cb_avg);
            compare_field("cr_average", want.cr_avg, got.cr_avg);
            compare_field("chroma_valid", 8'(want.chroma_valid), 8'(got.chroma_valid));
            compare_field("frame_last", 8'(want.frame_last), 8'(got.frame_last));
        endfunction

        function int pending();
            return expected_pixels.size();
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [TDATA_W-1:0]    s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [TDATA_W-1:0]    m_axis_tdata;
    logic                  m_axis_tuser;
    logic                  m_axis_tlast;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    downsample_scoreboard sb;
    int                   cycle_count = 0;
    int                   burst_left = 0;
    int                   rx_hold = 0;
    rx_mode_t             rx_mode = RX_ALWAYS;

    chroma_downsample_420_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // The sink switches between stall patterns at random intervals.
    always @(negedge clk)
    begin
        if (rx_hold == 0) begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            rx_hold = $urandom_range(16, 160);
        end
        rx_hold--;
        case (rx_mode)
            RX_ALWAYS:  m_axis_tready <= 1'b1;
            RX_LIGHT:   m_axis_tready <= ($urandom_range(0, 3) != 0);
            RX_HEAVY:   m_axis_tready <= ($urandom_range(0, 3) == 0);
            default:    m_axis_tready <= ((rx_hold % 5) != 0);
        endcase
    end

    always @(posedge clk)
    begin
        pixel_result_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            got.luma         = m_axis_tdata[7:0];
            got.cb_avg       = m_axis_tdata[15:8];
            got.cr_avg       = m_axis_tdata[23:16];
            got.chroma_valid = m_axis_tuser;
            got.frame_last   = m_axis_tlast;
            sb.check_result(got);
        end
    end

    // All driving tasks start and end just after a falling edge at which
    // nothing has been assigned yet.
    task automatic push_pixel(input logic [7:0] y, input logic [7:0] cb,
                              input logic [7:0] cr);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {cr, cb, y};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        sb.note_pixel(y, cb, cr);
        @(negedge clk);
    endtask

    task automatic drain_outputs();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sb.set_register(idx, data);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic push_random_pixel();
        logic [7:0] ch [3];
        for (int k = 0; k < 3; k++) begin
            case ($urandom_range(0, 7))
                0:       ch[k] = 8'h00;
                1:       ch[k] = 8'hFF;
                default: ch[k] = 8'($urandom_range(0, 255));
            endcase
        end
        if ($urandom_range(0, 99) == 0)
            drain_outputs();
        push_pixel(ch[0], ch[1], ch[2]);
    endtask

    // One size setting and a stretch of pixels under it. Sizes change only on
    // an even row, so every line store entry an odd row reads is written.
    task automatic run_phase(output int unsigned sent);
        int unsigned w_val;
        int unsigned h_val;
        int unsigned frame_px;
        int unsigned len;
        int          skip;
        case ($urandom_range(0, 9))
            0: begin
                w_val = $urandom_range(0, 1);
                h_val = $urandom_range(0, 1);
                len   = $urandom_range(4, 16);
            end
            1: begin
                w_val = ($urandom_range(0, 1) != 0) ? MAX_W : $urandom_range(MAX_W + 1, 8191);
                h_val = $urandom_range(1, 3);
                len   = $urandom_range(10, 60);
            end
            2: begin
                w_val = $urandom_range(1, 3);
                h_val = ($urandom_range(0, 1) != 0) ? 8191 : $urandom_range(MAX_H, 8191);
                len   = $urandom_range(20, 80);
            end
            default: begin
                w_val = $urandom_range(1, 6);
                h_val = $urandom_range(1, 3);
                frame_px = 4 * w_val * h_val;
                len = frame_px * $urandom_range(1, 3);
                if ($urandom_range(0, 3) == 0)
                    len += $urandom_range(1, frame_px);
            end
        endcase
        drain_outputs();
        skip = $urandom_range(0, 9);
        if ($urandom_range(0, 5) == 0)
            write_reg(($urandom_range(0, 1) != 0) ? REG_UNUSED_2 : REG_UNUSED_3,
                      CFG_DATA_W'($urandom_range(0, 8191)));
        if ($urandom_range(0, 1) != 0) begin
            if (skip != 0)
                write_reg(REG_WIDTH_PAIRS, CFG_DATA_W'(w_val));
            if (skip != 1)
                write_reg(REG_HEIGHT_PAIRS, CFG_DATA_W'(h_val));
        end
        else begin
            if (skip != 1)
                write_reg(REG_HEIGHT_PAIRS, CFG_DATA_W'(h_val));
            if (skip != 0)
                write_reg(REG_WIDTH_PAIRS, CFG_DATA_W'(w_val));
        end
        sent = 0;
        while (sent < len || sb.row_odd) begin
            push_random_pixel();
            sent++;
        end
    endtask

    initial
    begin
        int unsigned random_items;
        int unsigned sent;
        sb = new();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < 24; i++) begin
            if (i == 8) begin
                // Shrink mid-row: the pair in progress finishes, then wraps.
                drain_outputs();
                write_reg(REG_WIDTH_PAIRS, 13'd0);
                write_reg(REG_HEIGHT_PAIRS, 13'd1);
                write_reg(REG_UNUSED_2, 13'h1FFF);
                write_reg(REG_UNUSED_3, 13'h0AAA);
            end
            push_pixel(OPENING_PIXELS[i[4:0]][7:0], OPENING_PIXELS[i[4:0]][15:8],
                       OPENING_PIXELS[i[4:0]][23:16]);
        end

        random_items = 0;
        while (random_items < RANDOM_PIXELS) begin
            run_phase(sent);
            random_items += sent;
        end

        drain_outputs();
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/cds420_pkg.sv
rtl/core/cds420_line_store.sv
rtl/core/cds420_ctrl.sv
rtl/core/chroma_downsample_420_unit.sv
rtl/core/cds420_checker.sv
test/chroma_downsample_420_unit_test.sv
